// ===== sv/bfct_pkg.sv =====
// Shared constants, codes and control types for the best-fit count table.
`timescale 1ns / 1ps

package bfct_pkg;

  // Table depth and min-tree geometry
  localparam int ENTRIES = 64;
  localparam int LVL     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int LEAVES  = 1 << LVL;
  localparam int MID     = LVL / 2;
  localparam int MIDN    = 1 << MID;

  localparam int KEY_W  = 16;
  localparam int CNT_W  = 16;
  localparam int FUNC_W = 2;
  localparam int STAT_W = 2;
  localparam int NODE_W = KEY_W + 1;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Operation codes
  localparam logic [FUNC_W-1:0] OP_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] OP_GET    = 2'd1;
  localparam logic [FUNC_W-1:0] OP_SELECT = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_NONE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic cmp_en;
    logic min_en;
    logic commit;
  } bfct_cmd_t;

endpackage

// ===== sv/bfct_ctrl.sv =====
// Sequencing state machine and output valid control for the best-fit count table.
`timescale 1ns / 1ps

module bfct_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  input  logic              m_tready_i,
  output logic              s_tready_o,
  output logic              m_tvalid_o,
  output bfct_pkg::bfct_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_MIN  = 2'd2;
  localparam logic [1:0] S_UPD  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       commit;

  // Commit only once the output register is free or being drained
  assign commit = (state_q == S_UPD) && (!out_valid_q || m_tready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          state_d = S_CMP;
        end
      end
      S_CMP:   state_d = S_MIN;
      S_MIN:   state_d = S_UPD;
      S_UPD: begin
        if (commit) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_tready_o    = (state_q == S_IDLE);
  assign m_tvalid_o    = out_valid_q;
  assign cmd_o.load    = (state_q == S_IDLE) && s_tvalid_i;
  assign cmd_o.cmp_en  = (state_q == S_CMP);
  assign cmd_o.min_en  = (state_q == S_MIN);
  assign cmd_o.commit  = commit;

endmodule

// ===== sv/bfct_datapath.sv =====
// Entry cells, parallel compares, registered min tree and result register.
`timescale 1ns / 1ps

module bfct_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bfct_pkg::bfct_cmd_t           cmd_i,
  input  logic [bfct_pkg::FUNC_W-1:0]   func_i,
  input  logic [bfct_pkg::KEY_W-1:0]    size_key_i,
  input  logic [bfct_pkg::CNT_W-1:0]    amount_i,
  output logic [bfct_pkg::CNT_W-1:0]    result_value_o,
  output logic [bfct_pkg::STAT_W-1:0]   status_o
);

  localparam int N = bfct_pkg::ENTRIES;

  // Latched request
  logic [bfct_pkg::FUNC_W-1:0] func_q;
  logic [bfct_pkg::KEY_W-1:0]  req_q;
  logic [bfct_pkg::CNT_W-1:0]  amt_q;

  // Entry cells
  logic [bfct_pkg::KEY_W-1:0]  key_q [N];
  logic [bfct_pkg::CNT_W-1:0]  cnt_q [N];
  logic [N-1:0]                valid_q;

  // Compare stage
  logic [N-1:0]                hit_d, hit_q, ge_d, ge_q, free_d, free_q;
  logic [bfct_pkg::CNT_W-1:0]  cnt_sel_d, cnt_sel_q;
  logic [bfct_pkg::NODE_W-1:0] t1 [1:2*bfct_pkg::LEAVES-1];
  logic [bfct_pkg::NODE_W-1:0] mid_q [bfct_pkg::MIDN];

  // Min stage
  logic [bfct_pkg::NODE_W-1:0] t2 [1:2*bfct_pkg::MIDN-1];
  logic [bfct_pkg::NODE_W-1:0] min_q;

  // Commit
  logic [bfct_pkg::CNT_W:0]    sum;
  logic [bfct_pkg::CNT_W-1:0]  new_cnt;
  logic                        any_hit, any_free, found;
  logic [bfct_pkg::KEY_W-1:0]  min_key;
  logic [bfct_pkg::CNT_W-1:0]  res_d;
  logic [bfct_pkg::STAT_W-1:0] stat_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      req_q  <= size_key_i;
      amt_q  <= amount_i;
    end
  end

  always_comb begin
    cnt_sel_d = '0;
    for (int i = 0; i < N; i++) begin
      hit_d[i] = valid_q[i] && (key_q[i] == req_q);
      ge_d[i]  = valid_q[i] && (key_q[i] >= req_q);
      if (hit_d[i]) begin
        cnt_sel_d = cnt_sel_d | cnt_q[i];
      end
    end
    // Lowest free entry, one-hot
    free_d = ~valid_q & (valid_q + N'(1));
  end

  // Lower half of the min tree; keys are unique among valid entries.
  // Entries that do not qualify sit at all ones, whatever their stored key.
  always_comb begin
    for (int n = 1; n < 2 * bfct_pkg::LEAVES; n++) begin
      t1[n] = '1;
    end
    for (int i = 0; i < N; i++) begin
      t1[bfct_pkg::LEAVES + i] = ge_d[i] ? {1'b0, key_q[i]} : '1;
    end
    for (int n = bfct_pkg::LEAVES - 1; n >= bfct_pkg::MIDN; n--) begin
      t1[n] = (t1[2*n] < t1[2*n+1]) ? t1[2*n] : t1[2*n+1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp_en) begin
      hit_q     <= hit_d;
      ge_q      <= ge_d;
      free_q    <= free_d;
      cnt_sel_q <= cnt_sel_d;
      for (int j = 0; j < bfct_pkg::MIDN; j++) begin
        mid_q[j] <= t1[bfct_pkg::MIDN + j];
      end
    end
  end

  // Upper half of the min tree
  always_comb begin
    for (int j = 0; j < bfct_pkg::MIDN; j++) begin
      t2[bfct_pkg::MIDN + j] = mid_q[j];
    end
    for (int n = bfct_pkg::MIDN - 1; n >= 1; n--) begin
      t2[n] = (t2[2*n] < t2[2*n+1]) ? t2[2*n] : t2[2*n+1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.min_en) begin
      min_q <= t2[1];
    end
  end

  assign sum      = {1'b0, cnt_sel_q} + {1'b0, amt_q};
  assign new_cnt  = sum[bfct_pkg::CNT_W] ? bfct_pkg::CNT_MAX : sum[bfct_pkg::CNT_W-1:0];
  assign any_hit  = |hit_q;
  assign any_free = |free_q;
  assign found    = ~min_q[bfct_pkg::KEY_W];
  assign min_key  = min_q[bfct_pkg::KEY_W-1:0];

  always_comb begin
    res_d  = '0;
    stat_d = bfct_pkg::ST_OK;
    case (func_q)
      bfct_pkg::OP_ADD: begin
        if (any_hit) begin
          res_d = new_cnt;
        end else if (any_free) begin
          res_d = amt_q;
        end else begin
          stat_d = bfct_pkg::ST_FULL;
        end
      end
      bfct_pkg::OP_GET: res_d = cnt_sel_q;
      bfct_pkg::OP_SELECT: begin
        if (found) begin
          res_d = min_key;
        end else begin
          stat_d = bfct_pkg::ST_NONE;
        end
      end
      default: begin
        res_d  = '0;
        stat_d = bfct_pkg::ST_OK;
      end
    endcase
  end

  // Each cell updates itself from the broadcast commit
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic add_hit, add_new, sel;

    assign add_hit = (func_q == bfct_pkg::OP_ADD) && hit_q[i];
    assign add_new = (func_q == bfct_pkg::OP_ADD) && !any_hit && free_q[i];
    assign sel     = (func_q == bfct_pkg::OP_SELECT) && found && ge_q[i]
                     && (key_q[i] == min_key);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else if (cmd_i.commit) begin
        if (add_new) begin
          valid_q[i] <= 1'b1;
        end else if (sel && (cnt_q[i] <= bfct_pkg::CNT_W'(1))) begin
          valid_q[i] <= 1'b0;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.commit) begin
        if (add_hit) begin
          cnt_q[i] <= new_cnt;
        end else if (add_new) begin
          key_q[i] <= req_q;
          cnt_q[i] <= amt_q;
        end else if (sel) begin
          cnt_q[i] <= (cnt_q[i] <= bfct_pkg::CNT_W'(1)) ? '0 : cnt_q[i] - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      result_value_o <= res_d;
      status_o       <= stat_d;
    end
  end

endmodule

// ===== sv/best_fit_count_table_core.sv =====
// Top level of the best-fit count table: stream ports, controller and datapath.
`timescale 1ns / 1ps
// Usage:
//   Slave stream carries one command per transaction: add an amount to a
//   key's count, get a key's count, or select the smallest stored key that
//   is at least the requested size (its count drops by one, and the entry
//   is freed when that count is used up). Master stream returns exactly one
//   result transaction per command: a value and a status code.
//   Timing: a command is taken in the idle state, then the compare state does
//   the parallel key compares plus the lower min-tree levels, the min state
//   the upper levels, and the update state commits: it updates the table and
//   loads the output register. A new command is accepted only after the
//   previous one has committed, because of the two-stage min tree and the
//   read-modify-write of the entry cells, since each command sees the table
//   left by the previous one.
//   Reset empties the table (all entries free) and drops any pending result.
//   When the receiver stalls, the result holds in the output register; the
//   next command is still accepted and runs up to its commit cycle, where it
//   waits until the previous result has been taken.

module best_fit_count_table_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [39:0] s_tdata_i,   // [1:0] func, [17:2] size_key, [33:18] amount, zero fill
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [23:0] m_tdata_o    // [15:0] result_value, [17:16] status, zero fill
);

  bfct_pkg::bfct_cmd_t             cmd;
  logic [bfct_pkg::CNT_W-1:0]      result_value;
  logic [bfct_pkg::STAT_W-1:0]     status;

  bfct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .m_tready_i (m_tready_i),
    .s_tready_o (s_tready_o),
    .m_tvalid_o (m_tvalid_o),
    .cmd_o      (cmd)
  );

  bfct_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .func_i         (s_tdata_i[1:0]),
    .size_key_i     (s_tdata_i[17:2]),
    .amount_i       (s_tdata_i[33:18]),
    .result_value_o (result_value),
    .status_o       (status)
  );

  // Pack the result; upper bits stay zero
  assign m_tdata_o = {6'b0, status, result_value};

endmodule

// ===== tb/sv/count_table_checker.sv =====
// Checker for the best-fit count table: predicts each command's result and compares.
`timescale 1ns / 1ps

module count_table_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [39:0] s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [23:0] m_tdata_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_o,
  output int unsigned full_cnt_o,
  output int unsigned miss_cnt_o
);

  typedef struct packed {
    logic [bfct_pkg::CNT_W-1:0]  value;
    logic [bfct_pkg::STAT_W-1:0] status;
  } table_result_t;

  logic [bfct_pkg::KEY_W-1:0] slot_key   [bfct_pkg::ENTRIES];
  logic [bfct_pkg::CNT_W-1:0] slot_count [bfct_pkg::ENTRIES];
  logic                       slot_used  [bfct_pkg::ENTRIES];

  table_result_t owed_results [$];

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_cnt_o++;
  endtask

  function automatic int slot_of_key(input logic [bfct_pkg::KEY_W-1:0] k);
    for (int i = 0; i < bfct_pkg::ENTRIES; i++) begin
      if (slot_used[i] && slot_key[i] == k) return i;
    end
    return -1;
  endfunction

  // Apply one command to the shadow table and return the result it owes.
  function automatic table_result_t table_apply(input logic [39:0] word);
    logic [bfct_pkg::FUNC_W-1:0] op;
    logic [bfct_pkg::KEY_W-1:0]  k;
    logic [bfct_pkg::CNT_W-1:0]  amt;
    logic [bfct_pkg::CNT_W:0]    sum;
    int                          idx;
    table_result_t               res;
    op         = word[1:0];
    k          = word[17:2];
    amt        = word[33:18];
    res.value  = '0;
    res.status = bfct_pkg::ST_OK;
    idx        = -1;
    case (op)
      bfct_pkg::OP_ADD: begin
        idx = slot_of_key(k);
        if (idx >= 0) begin
          sum = {1'b0, slot_count[idx]} + {1'b0, amt};
          if (sum > {1'b0, bfct_pkg::CNT_MAX}) sum = {1'b0, bfct_pkg::CNT_MAX};
          slot_count[idx] = sum[bfct_pkg::CNT_W-1:0];
          res.value       = sum[bfct_pkg::CNT_W-1:0];
        end else begin
          // new key goes to the lowest free slot
          for (int i = 0; i < bfct_pkg::ENTRIES && idx < 0; i++) begin
            if (!slot_used[i]) idx = i;
          end
          if (idx >= 0) begin
            slot_used[idx]  = 1'b1;
            slot_key[idx]   = k;
            slot_count[idx] = amt;
            res.value       = amt;
          end else begin
            res.status = bfct_pkg::ST_FULL;
          end
        end
      end
      bfct_pkg::OP_GET: begin
        idx = slot_of_key(k);
        if (idx >= 0) res.value = slot_count[idx];
      end
      bfct_pkg::OP_SELECT: begin
        for (int i = 0; i < bfct_pkg::ENTRIES; i++) begin
          if (slot_used[i] && slot_key[i] >= k &&
              (idx < 0 || slot_key[i] < slot_key[idx])) idx = i;
        end
        if (idx >= 0) begin
          res.value = slot_key[idx];
          if (slot_count[idx] <= 1) begin
            slot_used[idx]  = 1'b0;
            slot_count[idx] = '0;
          end else begin
            slot_count[idx] = slot_count[idx] - 1'b1;
          end
        end else begin
          res.status = bfct_pkg::ST_NONE;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    table_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < bfct_pkg::ENTRIES; i++) slot_used[i] = 1'b0;
      owed_results.delete();
      pending_o      = 0;
      mismatch_cnt_o = 0;
      full_cnt_o     = 0;
      miss_cnt_o     = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (owed_results.size() == 0) begin
          report_mismatch($sformatf("result %h with no command outstanding", m_tdata_i));
        end else begin
          want = owed_results.pop_front();
          if (m_tdata_i[15:0] !== want.value)
            report_mismatch($sformatf("result_value %h, expected %h",
                                      m_tdata_i[15:0], want.value));
          if (m_tdata_i[17:16] !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      m_tdata_i[17:16], want.status));
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        want = table_apply(s_tdata_i);
        if (want.status == bfct_pkg::ST_FULL) full_cnt_o++;
        if (want.status == bfct_pkg::ST_NONE) miss_cnt_o++;
        owed_results.push_back(want);
      end
      pending_o = owed_results.size();
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Stimulus and verdict for the best-fit count table.
`timescale 1ns / 1ps

module testbench;

  localparam logic [bfct_pkg::FUNC_W-1:0] OP_RESERVED = 2'd3;
  localparam int RANDOM_ITEMS = 1680;
  localparam int BLOCK_LEN    = 100;
  localparam int POOL_SIZE    = 80;
  localparam int HOLD_AT      = 400;   // receiver hold-off starts here
  localparam int HOLD_CYCLES  = 120;
  localparam int PAUSE_AT     = 800;   // sender drains the block here
  localparam int CALM_TAIL    = 200;   // no idling in the last stretch
  localparam int CYCLE_LIMIT  = 300000;

  typedef enum logic [1:0] {MIX_FILL, MIX_BALANCED, MIX_DRAIN} mix_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // [1:0] func, [17:2] size_key, [33:18] amount, zero fill
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // [15:0] result_value, [17:16] status, zero fill

  int unsigned mismatch_cnt, pending_cnt, full_cnt, miss_cnt;
  int unsigned sent_cnt;
  int unsigned op_cnt [4];
  int unsigned cycle_cnt;
  bit          idle_en;
  bit          hold_done;

  logic [bfct_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
  int                         fill_idx;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  best_fit_count_table_core dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_tvalid),
    .s_tready_o(s_tready),
    .s_tdata_i (s_tdata),
    .m_tvalid_o(m_tvalid),
    .m_tready_i(m_tready),
    .m_tdata_o (m_tdata)
  );

  count_table_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_tvalid),
    .s_tready_i    (s_tready),
    .s_tdata_i     (s_tdata),
    .m_tvalid_i    (m_tvalid),
    .m_tready_i    (m_tready),
    .m_tdata_i     (m_tdata),
    .mismatch_cnt_o(mismatch_cnt),
    .pending_o     (pending_cnt),
    .full_cnt_o    (full_cnt),
    .miss_cnt_o    (miss_cnt)
  );

  // Receiver: one long hold-off once enough traffic is in flight, otherwise
  // short random stall bursts while idling is enabled.
  initial begin
    m_tready  = 1'b0;
    hold_done = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (!hold_done && sent_cnt >= HOLD_AT) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(0, 3)) @(negedge clk_i);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if the traffic never drains.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending_cnt);
    $display("TB_ERROR");
    $finish;
  end

  // Offer one command; hold it until the block takes the transaction.
  task automatic send_command(input logic [bfct_pkg::FUNC_W-1:0] func,
                              input logic [bfct_pkg::KEY_W-1:0] key,
                              input logic [bfct_pkg::CNT_W-1:0] amount);
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, amount, key, func};
    do @(posedge clk_i); while (!s_tready);
    sent_cnt++;
    op_cnt[func]++;
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic drain_results();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
  endtask

  function automatic logic [bfct_pkg::CNT_W-1:0] pick_amount();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return bfct_pkg::CNT_W'($urandom_range(1, 3));
    if (r < 75) return '0;
    if (r < 90) return bfct_pkg::CNT_W'($urandom);
    return bfct_pkg::CNT_W'($urandom_range(65000, 65535));
  endfunction

  // Keys mostly come from the pool so commands hit stored entries; selects
  // often ask a little below a pool key to exercise the lower bound.
  function automatic logic [bfct_pkg::KEY_W-1:0] pick_key(input bit for_select);
    int                         r;
    logic [bfct_pkg::KEY_W-1:0] k;
    r = $urandom_range(0, 99);
    if (r < 5) return bfct_pkg::KEY_W'($urandom);
    if (r < 7) return (r == 5) ? '0 : '1;
    k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (for_select && r < 45) begin
      k = (k > 50) ? k - bfct_pkg::KEY_W'($urandom_range(0, 50)) : '0;
    end
    return k;
  endfunction

  task automatic random_command(input mix_e mix);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      send_command(OP_RESERVED, bfct_pkg::KEY_W'($urandom), bfct_pkg::CNT_W'($urandom));
    end else if (mix == MIX_FILL) begin
      if (r < 88) begin
        send_command(bfct_pkg::OP_ADD, key_pool[fill_idx], pick_amount());
        fill_idx = (fill_idx + 1) % POOL_SIZE;
      end else if (r < 94) begin
        send_command(bfct_pkg::OP_GET, pick_key(1'b0), bfct_pkg::CNT_W'($urandom));
      end else begin
        send_command(bfct_pkg::OP_SELECT, pick_key(1'b1), bfct_pkg::CNT_W'($urandom));
      end
    end else if (mix == MIX_BALANCED) begin
      if (r < 40) send_command(bfct_pkg::OP_ADD, pick_key(1'b0), pick_amount());
      else if (r < 68) send_command(bfct_pkg::OP_GET, pick_key(1'b0),
                                    bfct_pkg::CNT_W'($urandom));
      else send_command(bfct_pkg::OP_SELECT, pick_key(1'b1), bfct_pkg::CNT_W'($urandom));
    end else begin
      if (r < 15) send_command(bfct_pkg::OP_ADD, pick_key(1'b0), pick_amount());
      else if (r < 28) send_command(bfct_pkg::OP_GET, pick_key(1'b0),
                                    bfct_pkg::CNT_W'($urandom));
      else send_command(bfct_pkg::OP_SELECT, pick_key(1'b1), bfct_pkg::CNT_W'($urandom));
    end
  endtask

  initial begin
    mix_e mix;
    int   done_random;
    rst_ni      = 1'b0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    sent_cnt    = 0;
    idle_en     = 1'b1;
    fill_idx    = 0;
    done_random = 0;
    foreach (op_cnt[i]) op_cnt[i] = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty table, zero amount, extremes, saturation, lower bound,
    // freeing on the last unit, absent keys and the unused function code.
    send_command(bfct_pkg::OP_SELECT, 16'h0000, 16'h0000);
    send_command(bfct_pkg::OP_GET,    16'h0000, 16'hFFFF);
    send_command(bfct_pkg::OP_ADD,    16'h0000, 16'h0000);
    send_command(bfct_pkg::OP_SELECT, 16'h0000, 16'h0000);
    send_command(bfct_pkg::OP_GET,    16'h0000, 16'h0000);
    send_command(bfct_pkg::OP_ADD,    16'hFFFF, 16'hFFFF);
    send_command(bfct_pkg::OP_ADD,    16'hFFFF, 16'h0001);
    send_command(bfct_pkg::OP_ADD,    16'd100,  16'd1);
    send_command(bfct_pkg::OP_ADD,    16'd200,  16'd2);
    send_command(bfct_pkg::OP_SELECT, 16'd101,  16'd0);
    send_command(bfct_pkg::OP_SELECT, 16'd150,  16'd0);
    send_command(bfct_pkg::OP_SELECT, 16'd150,  16'd0);
    send_command(bfct_pkg::OP_SELECT, 16'd100,  16'd0);
    send_command(bfct_pkg::OP_GET,    16'hFFFF, 16'h0000);
    send_command(OP_RESERVED,         16'hFFFF, 16'hFFFF);
    send_command(bfct_pkg::OP_GET,    16'd100,  16'd0);
    send_command(bfct_pkg::OP_ADD,    16'h5555, 16'hAAAA);
    send_command(bfct_pkg::OP_ADD,    16'hAAAA, 16'h5555);
    send_command(bfct_pkg::OP_SELECT, 16'h5556, 16'h0000);
    send_command(bfct_pkg::OP_SELECT, 16'hFFFF, 16'h0000);
    send_command(bfct_pkg::OP_GET,    16'h5555, 16'h0000);

    // Random blocks: the first fills the table past full, later ones mix.
    while (done_random < RANDOM_ITEMS) begin
      foreach (key_pool[i]) key_pool[i] = bfct_pkg::KEY_W'($urandom);
      if (done_random == 0) mix = MIX_FILL;
      else mix = mix_e'($urandom_range(0, 2));
      for (int n = 0; n < BLOCK_LEN && done_random < RANDOM_ITEMS; n++) begin
        if (sent_cnt == PAUSE_AT) drain_results();
        if (done_random == RANDOM_ITEMS - CALM_TAIL) idle_en = 1'b0;
        random_command(mix);
        done_random++;
      end
    end

    drain_results();
    repeat (8) @(negedge clk_i);

    $display("Ran %0d commands: %0d add, %0d get, %0d select, %0d with the unused code.",
             sent_cnt, op_cnt[bfct_pkg::OP_ADD], op_cnt[bfct_pkg::OP_GET],
             op_cnt[bfct_pkg::OP_SELECT], op_cnt[OP_RESERVED]);
    $display("Saw %0d table-full adds and %0d selects that found nothing, in %0d cycles.",
             full_cnt, miss_cnt, cycle_cnt);
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
